// ----- design/arpsc_pkg.sv -----
// Shared types and constants for the ARP binding spoof checker.
// No dependencies; imported by every module of the block.
package arpsc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int TYPE_W    = 16;
  localparam int OPCODE_W  = 16;
  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int VERDICT_W = 3;
  localparam int USED_W    = 11;

  localparam logic [TYPE_W-1:0]   ETYPE_ARP      = 16'h0806;
  localparam logic [OPCODE_W-1:0] OPCODE_REQUEST = 16'd1;
  localparam logic [OPCODE_W-1:0] OPCODE_REPLY   = 16'd2;

  typedef enum logic [VERDICT_W-1:0] {
    V_IGNORED = 3'd0,
    V_MATCH   = 3'd1,
    V_SPOOF   = 3'd2,
    V_STORED  = 3'd3,
    V_FULL    = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_entry;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } tbl_req_t;

endpackage

// ----- design/arp_binding_spoof_checker.sv -----
// ARP binding spoof checker: learns IP-to-MAC bindings from ARP replies and
// flags replies whose MAC differs from the one stored for the sender IP.
// Each accepted item gives one result. An item that is not an ARP reply
// goes through S_DONE into the output register; a reply is checked against
// the n stored bindings through the single read port of the binding
// table, which is scanned one entry per cycle until a match. A stalled output
// holds the result in S_DONE. Only one item is in work at a time; in_ready
// rises at the clock edge that loads a result, and the next item is taken while that
// result waits in the output register. Depends on arpsc_pkg, arpsc_seq and
// arpsc_table.
module arp_binding_spoof_checker
  import arpsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TYPE_W-1:0]    in_frame_type,
  input  logic [OPCODE_W-1:0]  in_arp_opcode,
  input  logic [IP_W-1:0]      in_src_ip,
  input  logic [MAC_W-1:0]     in_src_mac,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VERDICT_W-1:0] out_verdict,
  output logic [USED_W-1:0]    out_entries_used
);

  tbl_req_t               req;
  entry_t                 rd_entry;
  logic                   idle;
  logic                   res_valid;
  verdict_t               res_verdict;
  logic [CNT_W-1:0]       res_count;
  logic                   slot_free;
  logic                   out_valid_r, out_valid_nxt;
  logic [VERDICT_W-1:0]   out_verdict_r;
  logic [USED_W-1:0]      out_entries_used_r;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = idle;

  arpsc_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_valid && in_ready),
    .frame_type  (in_frame_type),
    .arp_opcode  (in_arp_opcode),
    .src_ip      (in_src_ip),
    .src_mac     (in_src_mac),
    .slot_free   (slot_free),
    .rd_entry    (rd_entry),
    .req         (req),
    .idle        (idle),
    .res_valid   (res_valid),
    .res_verdict (res_verdict),
    .res_count   (res_count)
  );

  arpsc_table u_table (
    .clk      (clk),
    .req      (req),
    .rd_entry (rd_entry)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid) begin
      out_verdict_r      <= res_verdict;
      out_entries_used_r <= USED_W'(res_count);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_entries_used = out_entries_used_r;

endmodule

// ----- design/arpsc_table.sv -----
// Binding table: one write port and one registered read port.
// Depends on arpsc_pkg for the entry type and table geometry.
module arpsc_table
  import arpsc_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output entry_t   rd_entry
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_entry_r <= mem[req.rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

// ----- design/arpsc_seq.sv -----
// Sequencer: scans the table one entry per cycle through the shared compare,
// then appends or reports; non-replies go straight to the report. Depends on arpsc_pkg; drives arpsc_table.
module arpsc_seq
  import arpsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [TYPE_W-1:0]   frame_type,
  input  logic [OPCODE_W-1:0] arp_opcode,
  input  logic [IP_W-1:0]     src_ip,
  input  logic [MAC_W-1:0]    src_mac,
  input  logic                slot_free,
  input  entry_t              rd_entry,
  output tbl_req_t            req,
  output logic                idle,
  output logic                res_valid,
  output verdict_t            res_verdict,
  output logic [CNT_W-1:0]    res_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  issue_idx_r, issue_idx_nxt;
  logic              pend_r, pend_nxt;
  logic              last_r, last_nxt;
  logic [IP_W-1:0]   ip_r, ip_nxt;
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  verdict_t          verdict_r, verdict_nxt;
  logic              is_reply;

  assign is_reply = (frame_type == ETYPE_ARP) && (arp_opcode == OPCODE_REPLY);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_idx_nxt = issue_idx_r;
    pend_nxt      = 1'b0;
    last_nxt      = last_r;
    ip_nxt        = ip_r;
    mac_nxt       = mac_r;
    verdict_nxt   = verdict_r;
    req           = '0;
    req.wr_addr   = count_r[ADDR_W-1:0];
    req.wr_entry  = '{ip: ip_r, mac: mac_r};
    req.rd_addr   = issue_idx_r[ADDR_W-1:0];
    res_valid     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ip_nxt        = src_ip;
          mac_nxt       = src_mac;
          issue_idx_nxt = '0;
          if (!is_reply) begin
            verdict_nxt = V_IGNORED;
            state_nxt   = S_DONE;
          end else if (count_r == '0) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && (rd_entry.ip == ip_r)) begin
          verdict_nxt = (rd_entry.mac == mac_r) ? V_MATCH : V_SPOOF;
          state_nxt   = S_DONE;
        end else if (pend_r && last_r) begin
          state_nxt = S_APPEND;
        end else begin
          req.rd_en     = 1'b1;
          pend_nxt      = 1'b1;
          last_nxt      = ((issue_idx_r + CNT_W'(1)) == count_r);
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
        end
      end
      S_APPEND: begin
        if (count_r < CNT_W'(TABLE_DEPTH)) begin
          req.wr_en   = 1'b1;
          count_nxt   = count_r + CNT_W'(1);
          verdict_nxt = V_STORED;
        end else begin
          verdict_nxt = V_FULL;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    issue_idx_r <= issue_idx_nxt;
    last_r      <= last_nxt;
    ip_r        <= ip_nxt;
    mac_r       <= mac_nxt;
    verdict_r   <= verdict_nxt;
  end

  assign idle        = (state_r == S_IDLE);
  assign res_verdict = verdict_r;
  assign res_count   = count_r;

endmodule
